// ===== hw/rtl/cmu_pkg.sv =====
// Shared constants and types for the classification metrics unit.
// No dependencies; used by classification_metrics_unit_top and its testbench.
`default_nettype none

package cmu_pkg;

	localparam int COUNT_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	// F-measure weight is Q1.16 regardless of the metric precision
	localparam int          ALPHA_BITS = 17;
	localparam int          ALPHA_FRAC = 16;
	localparam logic [16:0] ALPHA_ONE  = 17'h10000;
	localparam logic [16:0] ALPHA_RST  = 17'h08000;

	// ratio lanes of the first divider
	localparam int NUM_RATIOS = 7;

	typedef enum logic {
		REG_F_WEIGHT  = 1'b0,
		REG_ASCENDING = 1'b1
	} cfg_reg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cmu_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, several lanes.
// Computes floor(num * 2^SH / den), den == 0 gives 0. Uses no package items.
`default_nettype none

module cmu_div #(
	parameter int LANES = 1,
	parameter int DW    = 33,
	parameter int SH    = 16,
	parameter int QB    = 17,
	parameter int SBW   = 1
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [LANES-1:0][DW-1:0]   in_num,
	input  wire logic [LANES-1:0][DW-1:0]   in_den,
	input  wire logic [SBW-1:0]             in_sb,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [LANES-1:0][QB-1:0]        out_q,
	output logic [SBW-1:0]                  out_sb
);

	localparam int RW = DW + SH;
	localparam int CW = DW + SH + QB;

	logic [LANES-1:0][RW-1:0] rem_s [QB];
	logic [LANES-1:0][DW-1:0] den_s [QB];
	logic [LANES-1:0][QB-1:0] q_s   [QB];
	logic [SBW-1:0]           sb_s  [QB];
	logic [QB-1:0]            vld_s;
	logic [QB:0]              rdy;

	always_comb begin
		rdy[QB] = out_ready;
		for (int j = QB - 1; j >= 0; j--) begin
			rdy[j] = !vld_s[j] || rdy[j+1];
		end
	end

	assign in_ready = rdy[0];

	for (genvar j = 0; j < QB; j++) begin : g_stage
		localparam int B = QB - 1 - j;

		logic                     src_v;
		logic [LANES-1:0][RW-1:0] src_rem;
		logic [LANES-1:0][DW-1:0] src_den;
		logic [LANES-1:0][QB-1:0] src_q;
		logic [SBW-1:0]           src_sb;
		logic [LANES-1:0][RW-1:0] nxt_rem;
		logic [LANES-1:0][QB-1:0] nxt_q;

		if (j == 0) begin : g_first
			always_comb begin
				src_v   = in_valid;
				src_den = in_den;
				src_sb  = in_sb;
				for (int l = 0; l < LANES; l++) begin
					src_rem[l] = {in_num[l], {SH{1'b0}}};
					src_q[l]   = '0;
				end
			end
		end else begin : g_next
			always_comb begin
				src_v   = vld_s[j-1];
				src_rem = rem_s[j-1];
				src_den = den_s[j-1];
				src_q   = q_s[j-1];
				src_sb  = sb_s[j-1];
			end
		end

		always_comb begin
			logic [CW-1:0] sub;
			logic [CW-1:0] remx;
			logic          take;
			for (int l = 0; l < LANES; l++) begin
				sub        = CW'(src_den[l]) << B;
				remx       = CW'(src_rem[l]);
				take       = (src_den[l] != '0) && (remx >= sub);
				nxt_rem[l] = take ? RW'(remx - sub) : src_rem[l];
				nxt_q[l]   = src_q[l];
				nxt_q[l][B] = take;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (rdy[j]) begin
				vld_s[j] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[j] && src_v) begin
				rem_s[j] <= nxt_rem;
				den_s[j] <= src_den;
				q_s[j]   <= nxt_q;
				sb_s[j]  <= src_sb;
			end
		end
	end

	assign out_valid = vld_s[QB-1];
	assign out_q     = q_s[QB-1];
	assign out_sb    = sb_s[QB-1];

endmodule

`default_nettype wire

// ===== hw/rtl/classification_metrics_unit_top.sv =====
// Classification metrics unit, top level.
// Depends on cmu_pkg and cmu_div.
`default_nettype none

// One transaction on s_* carries the passed and total counts of positive and
// negative samples at one threshold; one transaction on m_* returns precision,
// false discovery rate, recall, specificity, fall-out, accuracy, negative
// predictive value and the weighted F-measure, each unsigned with FRAC_BITS
// fraction bits and rounded down. A zero denominator yields 0. When a passed
// count exceeds its total, m_tuser is set and all metrics are 0.
// Throughput is one transaction per clock while the output is not stalled. The
// pipeline is a register that forms the confusion matrix, FRAC_BITS + 1 stages
// of the ratio divider (one quotient bit each), a multiply stage, an add
// stage, and FRAC_BITS + 1 stages of the F-measure divider. Each stage holds
// its data under backpressure, so bubbles are squeezed out and the input keeps
// accepting while a result waits at the output. Configuration (cfg_index 0:
// f_weight, Q1.16, values above 1.0 are clamped; cfg_index 1: ascending) is
// always accepted and must only be written while the pipeline is empty.

module classification_metrics_unit_top #(
	parameter int COUNT_BITS = cmu_pkg::COUNT_BITS_DEF,
	parameter int FRAC_BITS  = cmu_pkg::FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// config write channel
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic                          cfg_index,
	input  wire logic [cmu_pkg::ALPHA_BITS-1:0] cfg_data,
	// counts in
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// pos_passed, pos_total, neg_passed, neg_total
	input  wire logic [((4*COUNT_BITS+7)/8)*8-1:0] s_tdata,
	// metrics out
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// precision, false_discovery, recall, specificity, fall_out, accuracy,
	// neg_pred_value, f_score
	output logic [((8*(FRAC_BITS+1)+7)/8)*8-1:0] m_tdata,
	// bad_counts
	output logic                               m_tuser
);

	localparam int CB    = COUNT_BITS;
	localparam int QB    = FRAC_BITS + 1;
	localparam int DWA   = CB + 1;
	localparam int NR    = cmu_pkg::NUM_RATIOS;
	localparam int AB    = cmu_pkg::ALPHA_BITS;
	localparam int MW    = AB + QB;
	localparam int DNB   = MW + 1;
	localparam int DWB   = (2 * QB > DNB) ? 2 * QB : DNB;
	localparam int RES_W = NR * QB;
	localparam int OUT_W = ((8 * QB + 7) / 8) * 8;
	localparam logic [QB-1:0] ONE_Q = QB'(1) << FRAC_BITS;

	// ---------------- configuration ----------------
	logic [AB-1:0] f_weight_q;
	logic          ascending_q;
	logic [AB-1:0] alpha;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_weight_q  <= cmu_pkg::ALPHA_RST;
			ascending_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cmu_pkg::cfg_reg_t'(cfg_index))
				cmu_pkg::REG_F_WEIGHT:  f_weight_q  <= cfg_data;
				cmu_pkg::REG_ASCENDING: ascending_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign alpha = (f_weight_q > cmu_pkg::ALPHA_ONE) ? cmu_pkg::ALPHA_ONE : f_weight_q;

	// ---------------- stage 1: confusion matrix ----------------
	logic [CB-1:0] pp, pt, np, nt;
	logic [CB-1:0] tp, fp, tn, fn;
	logic          bad;
	logic [NR-1:0][DWA-1:0] num_c, den_c;

	logic                   vld_s1;
	logic                   bad_s1;
	logic [NR-1:0][DWA-1:0] num_s1, den_s1;
	logic                   rdy_s1;
	logic                   diva_in_ready;

	assign pp = s_tdata[0*CB +: CB];
	assign pt = s_tdata[1*CB +: CB];
	assign np = s_tdata[2*CB +: CB];
	assign nt = s_tdata[3*CB +: CB];

	always_comb begin
		bad = (pp > pt) || (np > nt);
		if (ascending_q) begin
			tp = pt - pp; fp = nt - np; tn = np; fn = pp;
		end else begin
			tp = pp; fp = np; tn = nt - np; fn = pt - pp;
		end
		num_c[0] = DWA'(tp);      den_c[0] = DWA'(tp) + DWA'(fp);
		num_c[1] = DWA'(fp);      den_c[1] = DWA'(tp) + DWA'(fp);
		num_c[2] = DWA'(tp);      den_c[2] = DWA'(tp) + DWA'(fn);
		num_c[3] = DWA'(tn);      den_c[3] = DWA'(tn) + DWA'(fp);
		num_c[4] = DWA'(fp);      den_c[4] = DWA'(tn) + DWA'(fp);
		num_c[5] = DWA'(tp) + DWA'(tn);
		den_c[5] = DWA'(pt) + DWA'(nt);
		num_c[6] = DWA'(tn);      den_c[6] = DWA'(tn) + DWA'(fn);
		// inconsistent counts: zero numerators and denominators give all-zero ratios
		if (bad) begin
			num_c = '0;
			den_c = '0;
		end
	end

	assign rdy_s1   = !vld_s1 || diva_in_ready;
	assign s_tready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && s_tvalid) begin
			num_s1 <= num_c;
			den_s1 <= den_c;
			bad_s1 <= bad;
		end
	end

	// ---------------- ratio divider ----------------
	logic                  diva_out_valid;
	logic                  diva_out_ready;
	logic [NR-1:0][QB-1:0] diva_q;
	logic                  diva_bad;

	cmu_div #(
		.LANES (NR),
		.DW    (DWA),
		.SH    (FRAC_BITS),
		.QB    (QB),
		.SBW   (1)
	) u_div_ratio (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s1),
		.in_ready  (diva_in_ready),
		.in_num    (num_s1),
		.in_den    (den_s1),
		.in_sb     (bad_s1),
		.out_valid (diva_out_valid),
		.out_ready (diva_out_ready),
		.out_q     (diva_q),
		.out_sb    (diva_bad)
	);

	// ---------------- stage 2: F-measure products ----------------
	logic              vld_s2, bad_s2, rdy_s2;
	logic [RES_W-1:0]  res_s2;
	logic [2*QB-1:0]   pr_s2;
	logic [MW-1:0]     ar_s2, bp_s2;

	logic              vld_s3, bad_s3, rdy_s3;
	logic [RES_W-1:0]  res_s3;
	logic [DWB-1:0]    num_s3, den_s3;
	logic              divb_in_ready;

	assign rdy_s2         = !vld_s2 || rdy_s3;
	assign diva_out_ready = rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (rdy_s2) begin
			vld_s2 <= diva_out_valid;
		end
	end

	// P is lane 0, R is lane 2
	always_ff @(posedge clk) begin
		if (rdy_s2 && diva_out_valid) begin
			res_s2 <= diva_q;
			bad_s2 <= diva_bad;
			pr_s2  <= (2*QB)'(diva_q[0]) * (2*QB)'(diva_q[2]);
			ar_s2  <= MW'(alpha) * MW'(diva_q[2]);
			bp_s2  <= MW'(cmu_pkg::ALPHA_ONE - alpha) * MW'(diva_q[0]);
		end
	end

	// ---------------- stage 3: F-measure denominator ----------------
	assign rdy_s3 = !vld_s3 || divb_in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (rdy_s3) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && vld_s2) begin
			res_s3 <= res_s2;
			bad_s3 <= bad_s2;
			num_s3 <= DWB'(pr_s2);
			den_s3 <= DWB'(ar_s2) + DWB'(bp_s2);
		end
	end

	// ---------------- F-measure divider ----------------
	// zero P or R gives a zero product, so the quotient is 0 as required
	logic [0:0][QB-1:0]  divb_q;
	logic [RES_W:0]      divb_sb;

	cmu_div #(
		.LANES (1),
		.DW    (DWB),
		.SH    (cmu_pkg::ALPHA_FRAC),
		.QB    (QB),
		.SBW   (RES_W + 1)
	) u_div_fscore (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s3),
		.in_ready  (divb_in_ready),
		.in_num    (num_s3),
		.in_den    (den_s3),
		.in_sb     ({bad_s3, res_s3}),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_q     (divb_q),
		.out_sb    (divb_sb)
	);

	assign m_tdata = OUT_W'({divb_q[0], divb_sb[RES_W-1:0]});
	assign m_tuser = divb_sb[RES_W];

	// ---------------- assertions ----------------
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("flagged result carries nonzero metrics");

	a_prec_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[QB-1:0] <= ONE_Q)
		else $error("precision above 1.0");

	a_fscore_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7*QB +: QB] <= ONE_Q)
		else $error("f_score above 1.0");

	a_empty_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with no result pending");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking bench for classification_metrics_unit_top: streams count sets,
// predicts the metric set of each one and compares it field by field.
// Depends on cmu_pkg and the RTL of the unit.
`timescale 1ns / 100ps

module tb;

	localparam int CB = 32;
	localparam int FB = 16;
	localparam int LATENCY = 2*FB + 5;
	localparam int IN_W = ((4*CB+7)/8)*8;
	localparam int OUT_W = ((8*(FB+1)+7)/8)*8;
	localparam int LONG_HOLD = 120;

	typedef struct packed {
		logic [CB-1:0] neg_total;
		logic [CB-1:0] neg_passed;
		logic [CB-1:0] pos_total;
		logic [CB-1:0] pos_passed;
	} counts_t;

	typedef struct {
		logic [FB:0] m [8];
		logic        bad;
	} metrics_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_index;
	logic [cmu_pkg::ALPHA_BITS-1:0] cfg_data;
	logic s_tvalid;
	logic s_tready;
	logic [IN_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic m_tuser;

	classification_metrics_unit_top uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	// predictor's copy of the register file
	logic [16:0] weight_q;
	logic        ascend_q;

	counts_t  pending_counts[$];
	metrics_t expected_metrics[$];
	int       error_count = 0;
	bit       quiet_mode = 0;   // last part of the run: no idling
	bit       hold_request = 0; // asks the receiver for a long stall

	string metric_names[8] = '{"precision", "false_discovery", "recall", "specificity",
		"fall_out", "accuracy", "neg_pred_value", "f_score"};

	// floor(num * 2^FB / den), zero for a zero denominator
	function automatic logic [63:0] frac_quotient(logic [63:0] num, logic [63:0] den);
		logic [127:0] wide;
		if (den == 0)
			return 0;
		wide = {64'd0, num} << FB;
		return 64'(wide / den);
	endfunction

	function automatic metrics_t predict_metrics(counts_t c);
		metrics_t r;
		logic [63:0] tp, fp, tn, fn, p, rc, alpha, den;
		logic [127:0] wide;
		foreach (r.m[i]) r.m[i] = '0;
		r.bad = 1'b0;
		if (c.pos_passed > c.pos_total || c.neg_passed > c.neg_total) begin
			r.bad = 1'b1;
			return r;
		end
		if (ascend_q) begin
			tp = c.pos_total - c.pos_passed; fp = c.neg_total - c.neg_passed;
			tn = c.neg_passed; fn = c.pos_passed;
		end else begin
			tp = c.pos_passed; fp = c.neg_passed;
			tn = c.neg_total - c.neg_passed; fn = c.pos_total - c.pos_passed;
		end
		p  = frac_quotient(tp, tp + fp);
		rc = frac_quotient(tp, tp + fn);
		r.m[0] = p[FB:0];
		r.m[1] = (FB+1)'(frac_quotient(fp, tp + fp));
		r.m[2] = rc[FB:0];
		r.m[3] = (FB+1)'(frac_quotient(tn, tn + fp));
		r.m[4] = (FB+1)'(frac_quotient(fp, tn + fp));
		r.m[5] = (FB+1)'(frac_quotient(tp + tn, tp + tn + fp + fn));
		r.m[6] = (FB+1)'(frac_quotient(tn, tn + fn));
		// weight above one saturates
		alpha = (weight_q > cmu_pkg::ALPHA_ONE) ? 64'(cmu_pkg::ALPHA_ONE) : 64'(weight_q);
		if (p != 0 && rc != 0) begin
			den = alpha * rc + (64'(cmu_pkg::ALPHA_ONE) - alpha) * p;
			if (den != 0) begin
				wide = {64'd0, p * rc} << 16;
				r.m[7] = (FB+1)'(wide / den);
			end
		end
		return r;
	endfunction

	// clock
	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// driver: presents queued count sets, idles in random bursts
	int src_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			src_gap  = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_metrics.push_back(predict_metrics(counts_t'(s_tdata)));
				void'(pending_counts.pop_front());
			end
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_counts.size() > 0 &&
						(quiet_mode || $urandom_range(0, 7) != 0)) begin
					// valid may stay high across back-to-back transactions
					s_tvalid <= 1'b1;
					s_tdata  <= pending_counts[0];
				end else begin
					s_tvalid <= 1'b0;
					if (!quiet_mode && pending_counts.size() > 0)
						src_gap = $urandom_range(1, 9);
				end
			end
		end
	end

	// monitor and sink: compares each result with the oldest prediction
	int sink_gap = 0;
	int hold_cycles = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_gap = 0;
			hold_cycles = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_metrics.size() == 0) begin
					$error("unexpected result transaction");
					error_count++;
				end else begin
					metrics_t e;
					e = expected_metrics.pop_front();
					for (int i = 0; i < 8; i++)
						if (m_tdata[i*(FB+1) +: FB+1] !== e.m[i]) begin
							$error("%s: expected %0d, got %0d", metric_names[i], e.m[i],
								m_tdata[i*(FB+1) +: FB+1]);
							error_count++;
						end
					if (m_tuser !== e.bad) begin
						$error("bad_counts: expected %0d, got %0d", e.bad, m_tuser);
						error_count++;
					end
				end
			end
			if (hold_request && hold_cycles == 0)
				hold_cycles = LONG_HOLD;
			if (hold_cycles > 0) begin
				hold_cycles--;
				if (hold_cycles == 0)
					hold_request = 0;
				m_tready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				m_tready <= 1'b0;
			end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
				sink_gap = $urandom_range(1, 9);
				m_tready <= 1'b0;
			end else
				m_tready <= 1'b1;
		end
	end

	// random count in [0, hi]; mixes full-range, small and edge values
	function automatic logic [CB-1:0] rand_upto(logic [CB-1:0] hi);
		case ($urandom_range(0, 5))
			0: return hi;
			1: return 0;
			2: return (hi < 64) ? hi : $urandom_range(0, 63);
			default: return (hi == '1) ? $urandom : $urandom_range(0, hi);
		endcase
	endfunction

	function automatic counts_t random_counts();
		counts_t c;
		c.pos_total  = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 1000);
		c.neg_total  = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 1000);
		c.pos_passed = rand_upto(c.pos_total);
		c.neg_passed = rand_upto(c.neg_total);
		// some invalid sets where a passed count exceeds its total
		if ($urandom_range(0, 15) == 0) begin
			if (c.pos_total != '1 && $urandom_range(0, 1))
				c.pos_passed = $urandom_range(c.pos_total + 1, 32'hFFFF_FFFF);
			else if (c.neg_total != '1)
				c.neg_passed = $urandom_range(c.neg_total + 1, 32'hFFFF_FFFF);
		end
		return c;
	endfunction

	function automatic counts_t mk(logic [CB-1:0] pp, pt, np, nt);
		counts_t c;
		c.pos_passed = pp; c.pos_total = pt; c.neg_passed = np; c.neg_total = nt;
		return c;
	endfunction

	task automatic write_reg(cmu_pkg::cfg_reg_t idx, logic [16:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == cmu_pkg::REG_F_WEIGHT)
			weight_q = val;
		else
			ascend_q = val[0];
	endtask

	// wait until the pipeline has drained completely
	task automatic drain();
		while (pending_counts.size() > 0 || s_tvalid || expected_metrics.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic directed_set();
		pending_counts.push_back(mk(0, 0, 0, 0));
		pending_counts.push_back(mk('1, '1, '1, '1));
		pending_counts.push_back(mk(0, '1, 0, '1));
		pending_counts.push_back(mk('1, '1, 0, '1));
		pending_counts.push_back(mk(0, '1, '1, '1));
		pending_counts.push_back(mk(5, 10, 0, 0));
		pending_counts.push_back(mk(0, 0, 3, 7));
		pending_counts.push_back(mk(1, 0, 0, 0));          // passed above total
		pending_counts.push_back(mk(0, 0, '1, 32'hFFFF_FFFE));
		pending_counts.push_back(mk(1, 3, 2, 3));
		pending_counts.push_back(mk(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
		pending_counts.push_back(mk(7, 9, 1, 1000));
		pending_counts.push_back(mk(1, 1, 1, 1));
	endtask

	initial begin
		logic [16:0] weights[5] = '{17'h00000, 17'h10000, 17'h1FFFF, 17'h08000, 17'h04000};
		arst_n    = 0;
		cfg_valid = 0;
		cfg_index = cmu_pkg::REG_F_WEIGHT;
		cfg_data  = '0;
		weight_q  = cmu_pkg::ALPHA_RST;
		ascend_q  = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset values first
		directed_set();
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			write_reg(cmu_pkg::REG_F_WEIGHT, (ph < 5) ? weights[ph] : 17'($urandom));
			write_reg(cmu_pkg::REG_ASCENDING, 17'(ph[0]));
			if (ph < 2)
				directed_set();
			for (int k = 0; k < 180; k++)
				pending_counts.push_back(random_counts());
			if (ph == 2) begin
				// receiver stalls long while the sender keeps offering
				hold_request = 1;
			end
			if (ph == 5)
				quiet_mode = 1;
			drain();
		end

		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
